/* rtl/src_pkg.sv */
// Shared types and codes for the sorted record table.
// Used by src_cell, sorted_record_table and the testbench; depends on nothing else.
`default_nettype none

package src_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int KEY_BYTES_DEF = 8;
    localparam int KEY_W         = 64;
    localparam int AGE_W         = 7;
    localparam int CNT_W         = 6;

    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_DELETE = 3'd1;
    localparam logic [2:0] KIND_AGE    = 3'd2;
    localparam logic [2:0] KIND_LOOKUP = 3'd3;
    localparam logic [2:0] KIND_LIST   = 3'd4;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_NOMATCH = 2'd2;

    typedef struct packed {
        logic [2:0]       kind;
        logic [KEY_W-1:0] name_key;
        logic [KEY_W-1:0] city_key;
        logic [AGE_W-1:0] age;
    } t_in_word;

    typedef struct packed {
        logic [KEY_W-1:0] name_key_res;
        logic [KEY_W-1:0] city_key_res;
        logic [AGE_W-1:0] age_res;
        logic             found;
        logic             last;
        logic [1:0]       status;
        logic [CNT_W-1:0] entry_count;
    } t_out_word;

    typedef struct packed {
        logic [KEY_W-1:0] name;
        logic [KEY_W-1:0] city;
        logic [AGE_W-1:0] age;
    } t_rec;

    // Broadcast controls shared by every cell of the chain.
    typedef struct packed {
        logic ins;
        logic shift;
        logic keep;
        t_rec rec_new;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/src_cell.sv */
// One cell of the record chain: holds one record, inserts or shifts toward the head.
// Depends on src_pkg.
`default_nettype none

module src_cell
    import src_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  wire logic                       i_clk,
    input  wire t_cell_ctl                  i_ctl,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_n,
    input  wire logic [$clog2(DEPTH)-1:0]   i_wp,
    input  wire logic                       i_lt_prev,
    input  wire t_rec                       i_prev,
    input  wire t_rec                       i_next,
    input  wire t_rec                       i_head,
    output t_rec                            o_rec,
    output logic                            o_lt
);

    localparam int CntW = $clog2(DEPTH + 1);
    localparam int IdxW = $clog2(DEPTH);

    t_rec r_rec;
    t_rec n_rec;

    // Occupied and ordered before the incoming name.
    assign o_lt  = (CntW'(IDX) < i_n) && (r_rec.name < i_ctl.rec_new.name);
    assign o_rec = r_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.ins) begin
            if (o_lt) begin
                n_rec = r_rec;
            end else if (i_lt_prev) begin
                n_rec = i_ctl.rec_new;
            end else begin
                n_rec = i_prev;
            end
        end else if (i_ctl.shift) begin
            // advance toward the head; the write slot takes back the head word if it is kept
            if (i_ctl.keep && (i_wp == IdxW'(IDX))) begin
                n_rec = i_head;
            end else begin
                n_rec = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

`default_nettype wire

/* rtl/sorted_record_table.sv */
// Top level of the sorted record table: control sequencer over a chain of src_cell.
// Depends on src_pkg and src_cell.
`default_nettype none

// A table of up to DEPTH records kept in ascending name order in a chain of
// cells. A word is taken when start is high and busy is low. On an insert
// into a table that is not full, the record slides into place in all cells
// at once and its result word is registered together with it. Delete, age
// query, name lookup and list all rotate the n stored records one by one
// through the head cell of the chain, so busy stays high for one scan step
// per stored entry plus a close-out step; unused kinds leave busy low. Results
// come out with a strobe for one cycle each and must be taken as they appear:
// the receiver cannot stall. A query result is held back one match so that
// the final word carries last. The table needs no clearing after reset.
module sorted_record_table
    import src_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_in_word  i_word,
    output logic           o_strobe,
    output t_out_word      o_word
);

    localparam int CntW = $clog2(DEPTH + 1);
    localparam int IdxW = $clog2(DEPTH);
    localparam logic [KEY_W-1:0] KeyMask = ~{KEY_W{1'b0}} << (KEY_W - 8 * KEY_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [CntW-1:0] r_count, n_count;
    logic [CntW-1:0] r_n, n_n;
    logic [CntW-1:0] r_left, n_left;
    logic [CntW-1:0] r_j, n_j;
    logic [IdxW-1:0] r_wp, n_wp;
    logic [2:0] r_kind, n_kind;
    logic [KEY_W-1:0] r_nk, n_nk;
    logic [KEY_W-1:0] r_ck, n_ck;
    logic [AGE_W-1:0] r_age, n_age;
    t_rec r_pend, n_pend;
    logic r_pend_v, n_pend_v;
    logic r_strobe, n_strobe;
    t_out_word r_res, n_res;

    t_cell_ctl ctl;
    t_rec cell_rec [DEPTH];
    logic cell_lt [DEPTH];
    t_rec head;
    t_rec rec_in;
    logic accept;
    logic full;
    logic keep;
    logic match;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign full     = (r_count >= CntW'(DEPTH));
    assign head     = cell_rec[0];
    assign o_strobe = r_strobe;
    assign o_word   = r_res;

    assign rec_in.name = i_word.name_key & KeyMask;
    assign rec_in.city = i_word.city_key & KeyMask;
    assign rec_in.age  = i_word.age;

    assign keep = (r_kind == KIND_DELETE) ? (head.city != r_ck) : 1'b1;

    always_comb begin
        case (r_kind)
            KIND_AGE:    match = (head.age == r_age);
            KIND_LIST:   match = 1'b1;
            KIND_LOOKUP: match = (head.name == r_nk) && !r_pend_v;
            default:     match = 1'b0;
        endcase
    end

    assign ctl.ins     = accept && (i_word.kind == KIND_INSERT) && !full;
    assign ctl.shift   = (r_state == ST_SCAN);
    assign ctl.keep    = keep;
    assign ctl.rec_new = rec_in;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        src_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_n       (r_count),
            .i_wp      (r_wp),
            .i_lt_prev ((g == 0) ? 1'b1 : cell_lt[(g == 0) ? 0 : g - 1]),
            .i_prev    (cell_rec[(g == 0) ? 0 : g - 1]),
            .i_next    (cell_rec[(g == DEPTH - 1) ? 0 : g + 1]),
            .i_head    (head),
            .o_rec     (cell_rec[g]),
            .o_lt      (cell_lt[g])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_n      = r_n;
        n_left   = r_left;
        n_j      = r_j;
        n_wp     = r_wp;
        n_kind   = r_kind;
        n_nk     = r_nk;
        n_ck     = r_ck;
        n_age    = r_age;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_strobe = 1'b0;
        n_res    = r_res;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_kind   = i_word.kind;
                    n_nk     = rec_in.name;
                    n_ck     = rec_in.city;
                    n_age    = rec_in.age;
                    n_n      = r_count;
                    n_left   = r_count;
                    n_j      = '0;
                    n_wp     = IdxW'(r_count - CntW'(1));
                    n_pend_v = 1'b0;
                    n_res    = '0;
                    n_res.last = 1'b1;
                    case (i_word.kind)
                        KIND_INSERT: begin
                            n_strobe = 1'b1;
                            if (full) begin
                                n_res.status      = STATUS_FULL;
                                n_res.entry_count = CNT_W'(r_count);
                            end else begin
                                n_count            = r_count + CntW'(1);
                                n_res.name_key_res = rec_in.name;
                                n_res.city_key_res = rec_in.city;
                                n_res.age_res      = rec_in.age;
                                n_res.found        = 1'b1;
                                n_res.status       = STATUS_OK;
                                n_res.entry_count  = CNT_W'(r_count + CntW'(1));
                            end
                        end
                        KIND_DELETE, KIND_AGE, KIND_LOOKUP, KIND_LIST: begin
                            n_state = (r_count == '0) ? ST_DONE : ST_SCAN;
                        end
                        default: begin
                            n_strobe          = 1'b1;
                            n_res.status      = STATUS_OK;
                            n_res.entry_count = CNT_W'(r_count);
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_wp   = r_wp - IdxW'(1) + IdxW'(keep);
                n_j    = r_j + CntW'(keep);
                n_left = r_left - CntW'(1);
                if (match) begin
                    // flush the held match, it is not the final one
                    if (r_pend_v && (r_kind != KIND_LOOKUP)) begin
                        n_strobe           = 1'b1;
                        n_res.name_key_res = r_pend.name;
                        n_res.city_key_res = r_pend.city;
                        n_res.age_res      = r_pend.age;
                        n_res.found        = 1'b1;
                        n_res.last         = 1'b0;
                        n_res.status       = STATUS_OK;
                        n_res.entry_count  = CNT_W'(r_n);
                    end
                    n_pend   = head;
                    n_pend_v = 1'b1;
                end
                if (r_left == CntW'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state  = ST_IDLE;
                n_strobe = 1'b1;
                n_res    = '0;
                n_res.last = 1'b1;
                if (r_kind == KIND_DELETE) begin
                    n_count           = r_j;
                    n_res.status      = (r_j == r_n) ? STATUS_NOMATCH : STATUS_OK;
                    n_res.entry_count = CNT_W'(r_j);
                end else begin
                    n_res.entry_count = CNT_W'(r_n);
                    if (r_pend_v) begin
                        n_res.name_key_res = r_pend.name;
                        n_res.city_key_res = r_pend.city;
                        n_res.age_res      = r_pend.age;
                        n_res.found        = 1'b1;
                        n_res.status       = STATUS_OK;
                    end else begin
                        n_res.status = STATUS_NOMATCH;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_left <= n_left;
        r_j    <= n_j;
        r_wp   <= n_wp;
        r_kind <= n_kind;
        r_nk   <= n_nk;
        r_ck   <= n_ck;
        r_age  <= n_age;
        r_pend <= n_pend;
        r_res  <= n_res;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("entry count beyond table depth");

    a_wp_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CntW'(r_wp) < r_n))
        else $error("write slot outside the occupied part of the chain");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_word.found) |-> o_word.last)
        else $error("result without entry is not the final word");

    a_done_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> (o_strobe && o_word.last && !busy))
        else $error("close-out cycle gave no final word");

endmodule

`default_nettype wire

/* tb/sorted_record_table_tb.sv */
// Self-checking testbench for sorted_record_table: a sorted-table predictor and a result checker.
// Depends on src_pkg and the sorted_record_table RTL.
module sorted_record_table_tb
    import src_pkg::*;
();

    localparam int DEPTH          = DEPTH_DEF;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;

    localparam logic [KEY_W-1:0] KEY_MASK  = ~{KEY_W{1'b0}} << (KEY_W - 8 * KEY_BYTES_DEF);
    localparam logic [KEY_W-1:0] KEY_ONES  = ~{KEY_W{1'b0}};
    localparam logic [2:0]       KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0]       KIND_SPARE_MID   = 3'd6;
    localparam logic [2:0]       KIND_SPARE_LAST  = 3'd7;

    // String keys for the directed part
    localparam logic [KEY_W-1:0] KEY_BOB   = 64'h424F_4200_0000_0000;
    localparam logic [KEY_W-1:0] KEY_ALICE = 64'h414C_4943_4500_0000;
    localparam logic [KEY_W-1:0] KEY_ZED   = 64'h5A45_4400_0000_0000;
    localparam logic [KEY_W-1:0] KEY_ROME  = 64'h524F_4D45_0000_0000;
    localparam logic [KEY_W-1:0] KEY_OSLO  = 64'h4F53_4C4F_0000_0000;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_word  i_word  = '0;
    logic      o_strobe;
    t_out_word o_word;

    // Shadow copy of the table
    logic [KEY_W-1:0] name_tbl [DEPTH];
    logic [KEY_W-1:0] city_tbl [DEPTH];
    logic [AGE_W-1:0] age_tbl  [DEPTH];
    int               tbl_count = 0;

    t_out_word expected_words [$];
    int        mismatch_count = 0;
    int        idle_cycles    = 0;
    int        idle_pct       = 25;

    sorted_record_table u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_word   (i_word),
        .o_strobe (o_strobe),
        .o_word   (o_word)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void queue_result(input logic [KEY_W-1:0] nk, input logic [KEY_W-1:0] ck,
                                         input logic [AGE_W-1:0] ag, input logic found,
                                         input logic last, input logic [1:0] status);
        t_out_word res;
        res.name_key_res = nk;
        res.city_key_res = ck;
        res.age_res      = ag;
        res.found        = found;
        res.last         = last;
        res.status       = status;
        res.entry_count  = CNT_W'(tbl_count);
        expected_words.push_back(res);
    endfunction

    function automatic void predict_results(input t_in_word w);
        logic [KEY_W-1:0] nk;
        logic [KEY_W-1:0] ck;
        logic [AGE_W-1:0] ag;
        int               pos;
        int               j;
        int               keep;
        int               hits;
        int               seen;
        nk = w.name_key & KEY_MASK;
        ck = w.city_key & KEY_MASK;
        ag = w.age;
        case (w.kind)
            KIND_INSERT: begin
                if (tbl_count >= DEPTH) begin
                    queue_result('0, '0, '0, 1'b0, 1'b1, STATUS_FULL);
                end else begin
                    pos = 0;
                    while (pos < tbl_count && name_tbl[pos] < nk) pos++;
                    for (j = tbl_count; j > pos; j--) begin
                        name_tbl[j] = name_tbl[j-1];
                        city_tbl[j] = city_tbl[j-1];
                        age_tbl[j]  = age_tbl[j-1];
                    end
                    name_tbl[pos] = nk;
                    city_tbl[pos] = ck;
                    age_tbl[pos]  = ag;
                    tbl_count++;
                    queue_result(nk, ck, ag, 1'b1, 1'b1, STATUS_OK);
                end
            end
            KIND_DELETE: begin
                keep = 0;
                for (j = 0; j < tbl_count; j++) begin
                    if (city_tbl[j] != ck) begin
                        name_tbl[keep] = name_tbl[j];
                        city_tbl[keep] = city_tbl[j];
                        age_tbl[keep]  = age_tbl[j];
                        keep++;
                    end
                end
                hits = tbl_count - keep;
                tbl_count = keep;
                queue_result('0, '0, '0, 1'b0, 1'b1, (hits == 0) ? STATUS_NOMATCH : STATUS_OK);
            end
            KIND_AGE, KIND_LIST: begin
                hits = 0;
                for (j = 0; j < tbl_count; j++)
                    if (w.kind == KIND_LIST || age_tbl[j] == ag) hits++;
                if (hits == 0) begin
                    queue_result('0, '0, '0, 1'b0, 1'b1, STATUS_NOMATCH);
                end else begin
                    seen = 0;
                    for (j = 0; j < tbl_count; j++) begin
                        if (w.kind == KIND_LIST || age_tbl[j] == ag) begin
                            seen++;
                            queue_result(name_tbl[j], city_tbl[j], age_tbl[j], 1'b1,
                                         seen == hits, STATUS_OK);
                        end
                    end
                end
            end
            KIND_LOOKUP: begin
                pos = 0;
                while (pos < tbl_count && name_tbl[pos] != nk) pos++;
                if (pos < tbl_count)
                    queue_result(name_tbl[pos], city_tbl[pos], age_tbl[pos], 1'b1, 1'b1,
                                 STATUS_OK);
                else
                    queue_result('0, '0, '0, 1'b0, 1'b1, STATUS_NOMATCH);
            end
            default: begin
                queue_result('0, '0, '0, 1'b0, 1'b1, STATUS_OK);
            end
        endcase
    endfunction

    function automatic t_in_word make_word(input logic [2:0] kind, input logic [KEY_W-1:0] nk,
                                           input logic [KEY_W-1:0] ck,
                                           input logic [AGE_W-1:0] ag);
        t_in_word w;
        w.kind     = kind;
        w.name_key = nk;
        w.city_key = ck;
        w.age      = ag;
        return w;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // Short names from a small alphabet so that duplicates and hits are common
    function automatic logic [KEY_W-1:0] pool_name();
        if ($urandom_range(0, 99) < 30)
            return random_key();
        return {8'h41 + 8'($urandom_range(0, 5)), 8'h41 + 8'($urandom_range(0, 3)), 48'h0};
    endfunction

    function automatic logic [KEY_W-1:0] pool_city();
        if ($urandom_range(0, 99) < 20)
            return random_key();
        return {8'h41 + 8'($urandom_range(0, 3)), 56'h0};
    endfunction

    function automatic logic [AGE_W-1:0] pool_age();
        if ($urandom_range(0, 99) < 30)
            return AGE_W'($urandom_range(0, 127));
        return AGE_W'($urandom_range(18, 23));
    endfunction

    function automatic t_in_word next_random_word();
        t_in_word w;
        int       roll;
        int       pick;
        roll = $urandom_range(0, 99);
        pick = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
        w = make_word(KIND_INSERT, pool_name(), pool_city(), pool_age());
        if (roll < 42) begin
            w.kind = KIND_INSERT;
        end else if (roll < 56) begin
            w.kind = KIND_DELETE;
            if (tbl_count > 0 && $urandom_range(0, 99) < 60) w.city_key = city_tbl[pick];
        end else if (roll < 70) begin
            w.kind = KIND_AGE;
            if (tbl_count > 0 && $urandom_range(0, 99) < 70) w.age = age_tbl[pick];
        end else if (roll < 88) begin
            w.kind = KIND_LOOKUP;
            if (tbl_count > 0 && $urandom_range(0, 99) < 70) w.name_key = name_tbl[pick];
        end else if (roll < 96) begin
            w.kind = KIND_LIST;
        end else begin
            w = make_word(KIND_SPARE_FIRST + 3'($urandom_range(0, 2)), random_key(),
                          random_key(), AGE_W'($urandom_range(0, 127)));
        end
        return w;
    endfunction

    // Leaves start high after the accepting edge; callers that pause must drop it
    task automatic send_word(input t_in_word w);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        start  <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_results(w);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        // Empty table: every query misses, delete removes nothing
        send_word(make_word(KIND_LIST, '0, '0, '0));
        send_word(make_word(KIND_AGE, '0, '0, '0));
        send_word(make_word(KIND_LOOKUP, '0, '0, '0));
        send_word(make_word(KIND_DELETE, '0, '0, '0));
        send_word(make_word(KIND_SPARE_FIRST, KEY_ONES, KEY_ONES, 7'd127));
        send_word(make_word(KIND_SPARE_MID, '0, KEY_ONES, '0));
        send_word(make_word(KIND_SPARE_LAST, KEY_ONES, '0, 7'd127));
        send_word(make_word(KIND_INSERT, KEY_ONES, KEY_ONES, 7'd127));
        send_word(make_word(KIND_INSERT, '0, '0, '0));
        send_word(make_word(KIND_INSERT, KEY_BOB, KEY_ROME, 7'd40));
        // Equal name goes in front of the existing one
        send_word(make_word(KIND_INSERT, KEY_BOB, KEY_OSLO, 7'd41));
        send_word(make_word(KIND_INSERT, KEY_ALICE, KEY_ROME, 7'd40));
        send_word(make_word(KIND_LOOKUP, KEY_BOB, KEY_ONES, 7'd127));
        send_word(make_word(KIND_LOOKUP, KEY_ONES, '0, '0));
        send_word(make_word(KIND_LOOKUP, KEY_ZED, '0, '0));
        send_word(make_word(KIND_AGE, '0, '0, 7'd40));
        send_word(make_word(KIND_AGE, KEY_ONES, KEY_ONES, 7'd127));
        send_word(make_word(KIND_AGE, '0, '0, 7'd99));
        send_word(make_word(KIND_LIST, KEY_ONES, KEY_ONES, 7'd127));
        send_word(make_word(KIND_DELETE, '0, KEY_ROME, '0));
        send_word(make_word(KIND_DELETE, '0, KEY_ROME, '0));
        send_word(make_word(KIND_DELETE, KEY_ONES, '0, 7'd127));
        send_word(make_word(KIND_DELETE, '0, KEY_ONES, '0));
        send_word(make_word(KIND_LIST, '0, '0, '0));
        wait_drain();
    endtask

    task automatic test_full_table();
        while (tbl_count < DEPTH)
            send_word(make_word(KIND_INSERT, pool_name(), {8'h41 + 8'($urandom_range(0, 1)),
                                56'h0}, pool_age()));
        send_word(make_word(KIND_INSERT, pool_name(), pool_city(), pool_age()));
        send_word(make_word(KIND_LIST, '0, '0, '0));
        send_word(make_word(KIND_LOOKUP, name_tbl[DEPTH-1], '0, '0));
        send_word(make_word(KIND_AGE, '0, '0, age_tbl[0]));
        send_word(make_word(KIND_DELETE, '0, {8'h41, 56'h0}, '0));
        send_word(make_word(KIND_LIST, '0, '0, '0));
        wait_drain();
    endtask

    task automatic test_random(input int n_items, input int pct);
        int n;
        idle_pct = pct;
        for (n = 0; n < n_items; n++) begin
            send_word(next_random_word());
            // Hold off now and then until the table has answered everything
            if (n < n_items - 1 && $urandom_range(0, 99) < 3) wait_drain();
        end
        wait_drain();
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_strobe || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_strobe) begin
                if (expected_words.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("unexpected word: name=%h city=%h age=%0d status=%0d",
                                 o_word.name_key_res, o_word.city_key_res, o_word.age_res,
                                 o_word.status);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (want.name_key_res !== o_word.name_key_res ||
                        want.city_key_res !== o_word.city_key_res ||
                        want.age_res      !== o_word.age_res      ||
                        want.found        !== o_word.found        ||
                        want.last         !== o_word.last         ||
                        want.status       !== o_word.status       ||
                        want.entry_count  !== o_word.entry_count) begin
                        if (mismatch_count < MAX_REPORTS) begin
                            $display("mismatch exp: name=%h city=%h age=%0d f=%b l=%b st=%0d n=%0d",
                                     want.name_key_res, want.city_key_res, want.age_res,
                                     want.found, want.last, want.status, want.entry_count);
                            $display("         got: name=%h city=%h age=%0d f=%b l=%b st=%0d n=%0d",
                                     o_word.name_key_res, o_word.city_key_res, o_word.age_res,
                                     o_word.found, o_word.last, o_word.status,
                                     o_word.entry_count);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    initial begin : main
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 25;
        test_directed();
        test_full_table();
        test_random(135, 25);
        test_random(135, 56);
        test_random(140, 0);
        repeat (DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
